// ===== hw/rtl/skvt_pkg.sv =====
// Shared constants, types and codes of the sorted key/value table.
package skvt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_WIDTH   = 16;
	localparam int KEY_PORT_W  = 16;
	localparam int DATA_W      = 32;
	localparam int CAP_W       = 7;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W     = KEY_WIDTH + DATA_W;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DUP  = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} ram_req_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [DATA_W-1:0] value;
	} rsp_t;

endpackage

// ===== hw/rtl/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: config register, result register, sequencer, RAM.
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_we                 cfg_wdata (capacity limit)
//  request   in         req_valid/req_ready    opcode, key_address, data_value
//  result    out        rsp_valid/rsp_ready    status, read_value
//
// A lookup is a binary search: each step reads one RAM entry and compares its key.
// After the search, an insert shifts each stored entry with a larger key up one place and then
// writes the new entry; the RAM's single write port and single read port set the pace.
// Reset empties the table at once; the RAM contents are never cleared.
// The result register holds a result until taken; the next request is taken meanwhile.
module sorted_key_value_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [skvt_pkg::CAP_W-1:0]          cfg_wdata,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                opcode,
	input  logic [skvt_pkg::KEY_PORT_W-1:0]     key_address,
	input  logic signed [skvt_pkg::DATA_W-1:0]  data_value,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [1:0]                          status,
	output logic signed [skvt_pkg::DATA_W-1:0]  read_value
);

	logic [skvt_pkg::CAP_W-1:0]      cap_q;
	logic                            rsp_valid_q;
	logic [1:0]                      status_q;
	logic [skvt_pkg::DATA_W-1:0]     value_q;
	logic [31:0]                     key_ext;
	logic [skvt_pkg::KEY_WIDTH-1:0]  key;
	logic                            rsp_free;
	skvt_pkg::rsp_t                  rsp;
	skvt_pkg::ram_req_t              ram;
	logic [skvt_pkg::ENTRY_W-1:0]    rdata;

	assign key_ext  = 32'(key_address);
	assign key      = key_ext[skvt_pkg::KEY_WIDTH-1:0];
	assign rsp_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign read_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= skvt_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (rsp.valid && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.valid && rsp_free) begin
			status_q <= rsp.status;
			value_q  <= rsp.value;
		end
	end

	skvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cap       (cap_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.op        (skvt_pkg::op_t'(opcode)),
		.key       (key),
		.value     (data_value),
		.rsp       (rsp),
		.rsp_free  (rsp_free),
		.ram       (ram),
		.rdata     (rdata)
	);

	skvt_ram #(
		.WIDTH (skvt_pkg::ENTRY_W),
		.DEPTH (skvt_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

endmodule

// ===== hw/rtl/skvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module skvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/skvt_ctrl.sv =====
// Sequencer with shared key comparator: binary search and insertion shift.
module skvt_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [skvt_pkg::CAP_W-1:0]           cap,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  skvt_pkg::op_t                        op,
	input  logic [skvt_pkg::KEY_WIDTH-1:0]       key,
	input  logic [skvt_pkg::DATA_W-1:0]          value,
	output skvt_pkg::rsp_t                       rsp,
	input  logic                                 rsp_free,
	output skvt_pkg::ram_req_t                   ram,
	input  logic [skvt_pkg::ENTRY_W-1:0]         rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_SCMP,
		S_SHIFT,
		S_PLACE,
		S_RESP
	} state_t;

	state_t                          state_q;
	logic [skvt_pkg::CNT_W-1:0]      cnt_q;
	logic [skvt_pkg::CNT_W-1:0]      lo_q;
	logic [skvt_pkg::CNT_W-1:0]      hi_q;
	logic [skvt_pkg::CNT_W-1:0]      mid_q;
	logic [skvt_pkg::CNT_W-1:0]      i_q;
	skvt_pkg::op_t                   op_q;
	logic [skvt_pkg::KEY_WIDTH-1:0]  key_q;
	logic [skvt_pkg::DATA_W-1:0]     val_q;
	skvt_pkg::status_t               st_q;
	logic [skvt_pkg::DATA_W-1:0]     rval_q;

	logic [skvt_pkg::CNT_W-1:0]      mid;
	logic [skvt_pkg::CNT_W-1:0]      cnt_m1;
	logic [skvt_pkg::CNT_W-1:0]      i_m2;
	logic [skvt_pkg::KEY_WIDTH-1:0]  rkey;
	logic                            k_eq;
	logic                            k_lt;
	logic                            full;
	logic                            in_range;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign cnt_m1   = cnt_q - skvt_pkg::CNT_W'(1);
	assign i_m2     = i_q - skvt_pkg::CNT_W'(2);
	assign in_range = lo_q < hi_q;

	assign rkey = rdata[skvt_pkg::ENTRY_W-1:skvt_pkg::DATA_W];
	assign k_eq = rkey == key_q;
	assign k_lt = rkey < key_q;

	assign full = (32'(cnt_q) >= 32'(cap)) || (32'(cnt_q) >= 32'(skvt_pkg::TABLE_DEPTH));

	assign req_ready  = state_q == S_IDLE;
	assign rsp.valid  = state_q == S_RESP;
	assign rsp.status = st_q;
	assign rsp.value  = rval_q;

	always_comb begin
		ram = '0;
		unique case (state_q)
			S_SRCH: begin
				if (in_range) begin
					ram.re    = 1'b1;
					ram.raddr = mid[skvt_pkg::IDX_W-1:0];
				end else if (op_q == skvt_pkg::OP_INSERT && cnt_q != '0) begin
					ram.re    = 1'b1;
					ram.raddr = cnt_m1[skvt_pkg::IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				if (!k_eq && !k_lt) begin
					ram.we    = 1'b1;
					ram.waddr = i_q[skvt_pkg::IDX_W-1:0];
					ram.wdata = rdata;
					ram.re    = i_q != skvt_pkg::CNT_W'(1);
					ram.raddr = i_m2[skvt_pkg::IDX_W-1:0];
				end
			end
			S_PLACE: begin
				ram.we    = 1'b1;
				ram.waddr = i_q[skvt_pkg::IDX_W-1:0];
				ram.wdata = {key_q, val_q};
			end
			default: begin
				ram = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			i_q     <= '0;
			op_q    <= skvt_pkg::OP_INSERT;
			key_q   <= '0;
			val_q   <= '0;
			st_q    <= skvt_pkg::ST_OK;
			rval_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q  <= op;
						key_q <= key;
						val_q <= value;
						lo_q  <= '0;
						hi_q  <= cnt_q;
						if (op == skvt_pkg::OP_INSERT && full) begin
							st_q    <= skvt_pkg::ST_FULL;
							rval_q  <= '0;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (in_range) begin
						mid_q   <= mid;
						state_q <= S_SCMP;
					end else if (op_q == skvt_pkg::OP_LOOKUP) begin
						st_q    <= skvt_pkg::ST_MISS;
						rval_q  <= '0;
						state_q <= S_RESP;
					end else begin
						i_q     <= cnt_q;
						state_q <= (cnt_q == '0) ? S_PLACE : S_SHIFT;
					end
				end
				S_SCMP: begin
					if (k_eq) begin
						if (op_q == skvt_pkg::OP_LOOKUP) begin
							st_q   <= skvt_pkg::ST_OK;
							rval_q <= rdata[skvt_pkg::DATA_W-1:0];
						end else begin
							st_q   <= skvt_pkg::ST_DUP;
							rval_q <= '0;
						end
						state_q <= S_RESP;
					end else begin
						if (k_lt) begin
							lo_q <= mid_q + skvt_pkg::CNT_W'(1);
						end else begin
							hi_q <= mid_q;
						end
						state_q <= S_SRCH;
					end
				end
				S_SHIFT: begin
					if (!k_eq && !k_lt) begin
						i_q <= i_q - skvt_pkg::CNT_W'(1);
						if (i_q == skvt_pkg::CNT_W'(1)) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					cnt_q   <= cnt_q + skvt_pkg::CNT_W'(1);
					st_q    <= skvt_pkg::ST_OK;
					rval_q  <= '0;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/skvt_chk.sv =====
// Port-level checker for the sorted key/value table, bound to the top level.
module skvt_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic [1:0]                         status,
	input logic signed [skvt_pkg::DATA_W-1:0] read_value
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(read_value))
		else $error("result changed while stalled");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != skvt_pkg::ST_OK |-> read_value == '0)
		else $error("nonzero value on a refused or missed request");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is in work");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared in the cycle after a request");

endmodule

bind sorted_key_value_table skvt_chk u_skvt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.status     (status),
	.read_value (read_value)
);
